### sv/ofcc_pkg.sv
`default_nettype none

package ofcc_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned PosW = 4;
	localparam logic [ByteW-1:0] CrcPoly = 8'h8C;
	localparam logic [ByteW-1:0] CrcInit = 8'h00;
	localparam logic [PosW-1:0] FrameLenReset = 4'd8;

	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic             frame_start;
	} src_word_t;

	typedef struct packed {
		logic               crc_ok;
		logic [ByteW-1:0]   computed_crc;
		logic [ByteW-1:0]   received_crc;
		logic signed [15:0] temperature_word;
	} dst_word_t;

	// Reflected CRC-8, one byte folded in LSB first.
	function automatic logic [ByteW-1:0] crc_fold_byte(input logic [ByteW-1:0] crc_in,
			input logic [ByteW-1:0] b_in);
		logic [ByteW-1:0] crc;
		logic [ByteW-1:0] b;
		logic             fb;
		crc = crc_in;
		b   = b_in;
		for (int k = 0; k < ByteW; k++) begin
			fb  = crc[0] ^ b[0];
			crc = {1'b0, crc[ByteW-1:1]};
			if (fb) begin
				crc = crc ^ CrcPoly;
			end
			b = {1'b0, b[ByteW-1:1]};
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

### sv/ofcc_frame_unit.sv
`default_nettype none

module ofcc_frame_unit
	import ofcc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [PosW-1:0] frame_length,
	input  wire src_word_t       word_s1,
	input  wire logic            fire,
	output logic                 close,
	output dst_word_t            result
);

	logic [ByteW-1:0] crc_q;
	logic [PosW-1:0]  pos_q;
	logic [ByteW-1:0] byte0_q;
	logic [ByteW-1:0] byte1_q;

	logic [ByteW-1:0] crc_e;
	logic [PosW-1:0]  pos_e;
	logic [ByteW-1:0] byte0_e;
	logic [ByteW-1:0] byte1_e;
	logic [ByteW-1:0] crc_next;

	// frame_start wipes the frame before this word is handled
	always_comb begin
		if (word_s1.frame_start) begin
			crc_e   = CrcInit;
			pos_e   = '0;
			byte0_e = '0;
			byte1_e = '0;
		end else begin
			crc_e   = crc_q;
			pos_e   = pos_q;
			byte0_e = byte0_q;
			byte1_e = byte1_q;
		end
	end

	assign close    = (pos_e >= frame_length);
	assign crc_next = crc_fold_byte(crc_e, word_s1.data_byte);

	always_comb begin
		result.crc_ok           = (crc_e == word_s1.data_byte);
		result.computed_crc     = crc_e;
		result.received_crc     = word_s1.data_byte;
		result.temperature_word = $signed({byte1_e, byte0_e});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CrcInit;
			pos_q   <= '0;
			byte0_q <= '0;
			byte1_q <= '0;
		end else if (fire) begin
			if (close) begin
				crc_q   <= CrcInit;
				pos_q   <= '0;
				byte0_q <= '0;
				byte1_q <= '0;
			end else begin
				crc_q   <= crc_next;
				pos_q   <= pos_e + PosW'(1);
				byte0_q <= (pos_e == PosW'(0)) ? word_s1.data_byte : byte0_e;
				byte1_q <= (pos_e == PosW'(1)) ? word_s1.data_byte : byte1_e;
			end
		end
	end

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && close |=> pos_q == '0 && crc_q == CrcInit)
		else $error("frame state not cleared after CRC word");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !close |=> pos_q == $past(pos_e) + PosW'(1))
		else $error("byte position did not advance on data word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(pos_q) && $stable(crc_q))
		else $error("frame state moved without a word");

endmodule

`default_nettype wire

### sv/ofcc_out_reg.sv
`default_nettype none

module ofcc_out_reg
	import ofcc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire dst_word_t load_word,
	output logic           room,
	output logic           valid,
	input  wire logic      stall,
	output dst_word_t      word
);

	logic      valid_q;
	dst_word_t word_q;

	assign room  = !valid_q || !stall;
	assign valid = valid_q;
	assign word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			word_q <= load_word;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("result loaded while output word still held");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && stall |=> valid_q && $stable(word_q))
		else $error("held result changed under stall");

endmodule

`default_nettype wire

### sv/onewire_frame_crc_checker.sv
`default_nettype none

// 1-Wire frame CRC-8 checker (reflected, poly 0x8C, init 0).
// A word from src is registered in s1; when it retires, a CRC word loads its result
// into the output register, which drives dst. Throughput: one word per cycle, unless
// a CRC word waits in s1 for room; set by one input register, one CRC byte fold and
// the output register. Only CRC words make a result; data words make none.
// Reset (arst_n low, async): frame state cleared, frame_length back to 8,
// both pipeline registers empty.

module onewire_frame_crc_checker
	import ofcc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	// source channel: one received byte per word
	input  wire logic            src_valid,
	output logic                 src_stall,
	input  wire src_word_t       src_word,
	// result channel: one word per closed frame
	output logic                 dst_valid,
	input  wire logic            dst_stall,
	output dst_word_t            dst_word,
	// frame_length register
	input  wire logic            cfg_we,
	input  wire logic [PosW-1:0] cfg_wdata
);

	logic [PosW-1:0] frame_len_q;
	logic            valid_s1;
	src_word_t       word_s1;
	logic            close;
	logic            fire;
	logic            room;
	dst_word_t       result;

	// The user must write it only while no word is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= FrameLenReset;
		end else if (cfg_we) begin
			frame_len_q <= cfg_wdata;
		end
	end

	// A data word in s1 can always retire; a CRC word needs room downstream.
	assign fire      = valid_s1 && (!close || room);
	assign src_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			word_s1 <= src_word;
		end
	end

	// Frame state, CRC fold and result build.
	ofcc_frame_unit u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_length (frame_len_q),
		.word_s1      (word_s1),
		.fire         (fire),
		.close        (close),
		.result       (result)
	);

	// Result register toward the sink.
	ofcc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && close),
		.load_word (result),
		.room      (room),
		.valid     (dst_valid),
		.stall     (dst_stall),
		.word      (dst_word)
	);

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && close && !room)
		else $error("source stalled without a blocked CRC word");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && close |=> dst_valid)
		else $error("closed frame produced no result");

endmodule

`default_nettype wire

### bench/onewire_frame_crc_checker_tb.sv
`timescale 1ns / 100ps

module onewire_frame_crc_checker_tb;
	import ofcc_pkg::*;

	// Slack allowed for results after the closing word.
	localparam int SettleCycles = 4;
	// Worst case is well under this even with long gaps on both sides.
	localparam int CycleLimit = 2000000;
	localparam int PhaseWords = 170;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            src_valid = 1'b0;
	logic            src_stall;
	src_word_t       src_word = '0;
	logic            dst_valid;
	logic            dst_stall = 1'b0;
	dst_word_t       dst_word;
	logic            cfg_we = 1'b0;
	logic [PosW-1:0] cfg_wdata = '0;

	// Frame tracker: our own view of the checker state.
	logic [PosW-1:0]  frame_len = FrameLenReset;
	logic [PosW-1:0]  frame_pos = '0;
	logic [ByteW-1:0] running_crc = CrcInit;
	logic [ByteW-1:0] low_byte = '0;
	logic [ByteW-1:0] high_byte = '0;

	// One entry per closed frame, oldest first.
	dst_word_t closing_words [$];
	dst_word_t oldest;

	int  mismatch_count = 0;
	int  words_sent = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	// When set, neither side idles: back-to-back traffic.
	bit  calm = 1'b0;

	onewire_frame_crc_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Reflected CRC-8: xor the byte in, then shift out eight bits.
	function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] acc,
			input logic [ByteW-1:0] data);
		logic [ByteW-1:0] r;
		r = acc ^ data;
		repeat (ByteW) begin
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void clear_frame_model();
		frame_pos   = '0;
		running_crc = CrcInit;
		low_byte    = '0;
		high_byte   = '0;
	endfunction

	// Track one accepted word; a closing word queues the predicted result.
	function automatic void fold_frame_byte(input logic [ByteW-1:0] b, input logic start);
		dst_word_t res;
		// early restart: this word becomes byte zero
		if (start) begin
			clear_frame_model();
		end
		if (frame_pos < frame_len) begin
			if (frame_pos == 0) begin
				low_byte = b;
			end else if (frame_pos == 1) begin
				high_byte = b;
			end
			running_crc = crc8_step(running_crc, b);
			frame_pos   = frame_pos + 1'b1;
		end else begin
			// at or past the length: this word is the received CRC
			res.crc_ok           = (running_crc == b);
			res.computed_crc     = running_crc;
			res.received_crc     = b;
			res.temperature_word = {high_byte, low_byte};
			closing_words.push_back(res);
			clear_frame_model();
		end
	endfunction

	// Present one word, hold it until accepted, then maybe idle.
	task automatic send_byte(input logic [ByteW-1:0] b, input logic start);
		src_word_t w;
		int        gap;
		w.data_byte   = b;
		w.frame_start = start;
		src_word  <= w;
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		fold_frame_byte(b, start);
		words_sent++;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until every queued result is out and the pipe is empty.
	task automatic wait_idle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (closing_words.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_frame_length(input logic [PosW-1:0] len);
		wait_idle();
		cfg_wdata <= len;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		frame_len = len;
	endtask

	// Data bytes then a CRC byte; restart flag forced if a frame is half open.
	task automatic send_good_frame(input bit right_crc);
		logic [ByteW-1:0] crc_byte;
		for (int i = 0; i < frame_len; i++) begin
			send_byte(8'($urandom), (i == 0) && (frame_pos != 0 || $urandom_range(0, 1) == 1));
		end
		crc_byte = right_crc ? running_crc : 8'($urandom);
		send_byte(crc_byte, (frame_len == 0) && ($urandom_range(0, 1) == 1));
	endtask

	// Temperature sensor scratchpad at the reset length, -55 C reading.
	task automatic test_scratchpad();
		logic [ByteW-1:0] pad [8];
		pad = '{8'h90, 8'hFC, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10};
		foreach (pad[i]) begin
			send_byte(pad[i], i == 0);
		end
		send_byte(running_crc, 1'b0);
	endtask

	// Seven-byte ROM ID, family code first.
	task automatic test_rom_id();
		logic [ByteW-1:0] rom [7];
		rom = '{8'h28, 8'hFF, 8'h00, 8'hA2, 8'h5D, 8'h16, 8'h04};
		set_frame_length(4'd7);
		foreach (rom[i]) begin
			send_byte(rom[i], 1'b0);
		end
		send_byte(running_crc, 1'b0);
	endtask

	// One data byte: no high half. Bad CRC first, then an early restart.
	task automatic test_short_frame();
		set_frame_length(4'd1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b1);
		send_byte(running_crc, 1'b0);
	endtask

	// Empty frames: every word closes one, CRC and temperature are zero.
	task automatic test_zero_length();
		set_frame_length(4'd0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// Length drops under the current position: next word closes at once.
	task automatic test_length_lowered();
		set_frame_length(4'd15);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		set_frame_length(4'd2);
		send_byte(8'h5A, 1'b0);
	endtask

	// Mostly clean frames, some cut short, some plain noise.
	task automatic test_random_frames(input logic [PosW-1:0] len);
		int stop_at;
		int kind;
		int n;
		set_frame_length(len);
		stop_at = words_sent + PhaseWords;
		while (words_sent < stop_at) begin
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_good_frame(kind < 63);
			end else if (kind < 85) begin
				// broken frame; the next clean one restarts it
				n = $urandom_range(0, len);
				repeat (n) send_byte(8'($urandom), 1'b0);
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end
		calm = 1'b0;
	endtask

	task automatic report_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: check at each accepted word, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (closing_words.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, got %h",
					$time, dst_word);
				mismatch_count++;
			end else begin
				oldest = closing_words.pop_front();
				report_field("crc_ok", 16'(oldest.crc_ok), 16'(dst_word.crc_ok));
				report_field("computed_crc", 16'(oldest.computed_crc),
					16'(dst_word.computed_crc));
				report_field("received_crc", 16'(oldest.received_crc),
					16'(dst_word.received_crc));
				report_field("temperature_word", oldest.temperature_word,
					dst_word.temperature_word);
			end
		end
		if (stall_left != 0) begin
			dst_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			dst_stall <= 1'b0;
			if (!calm) begin
				stall_left <= pick_gap();
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("onewire_frame_crc_checker test failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_scratchpad();
		test_rom_id();
		test_short_frame();
		test_zero_length();
		test_length_lowered();

		test_random_frames(4'd8);
		test_random_frames(4'd7);
		test_random_frames(4'd15);
		test_random_frames(4'd1);
		test_random_frames(4'd0);
		test_random_frames(4'($urandom_range(0, 15)));
		test_random_frames(4'($urandom_range(0, 15)));
		test_random_frames(4'd8);

		wait_idle();
		if (mismatch_count == 0) begin
			$display("onewire_frame_crc_checker test passed");
		end else begin
			$display("onewire_frame_crc_checker test failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/ofcc_pkg.sv
sv/ofcc_frame_unit.sv
sv/ofcc_out_reg.sv
sv/onewire_frame_crc_checker.sv
bench/onewire_frame_crc_checker_tb.sv
